// ===== sv/tie_pkg.sv =====
// tie_pkg: opcode codes and field widths for the toy instruction executor
// no dependencies; imported by toy_instruction_executor
package tie_pkg;

  localparam int unsigned FUNC_W  = 5;
  localparam int unsigned RIDX_IN = 5;
  localparam int unsigned ADDR_IN = 8;
  localparam int unsigned WORD_W  = 32;

  localparam logic [FUNC_W-1:0] OP_NOP   = 5'd0;
  localparam logic [FUNC_W-1:0] OP_ADD   = 5'd1;
  localparam logic [FUNC_W-1:0] OP_SUB   = 5'd2;
  localparam logic [FUNC_W-1:0] OP_MULT  = 5'd3;
  localparam logic [FUNC_W-1:0] OP_DIV   = 5'd4;
  localparam logic [FUNC_W-1:0] OP_LI    = 5'd5;
  localparam logic [FUNC_W-1:0] OP_INC   = 5'd6;
  localparam logic [FUNC_W-1:0] OP_DEC   = 5'd7;
  localparam logic [FUNC_W-1:0] OP_JUMP  = 5'd8;
  localparam logic [FUNC_W-1:0] OP_BEQ   = 5'd9;
  localparam logic [FUNC_W-1:0] OP_BNE   = 5'd10;
  localparam logic [FUNC_W-1:0] OP_BGEZ  = 5'd11;
  localparam logic [FUNC_W-1:0] OP_BGTZ  = 5'd12;
  localparam logic [FUNC_W-1:0] OP_BLEZ  = 5'd13;
  localparam logic [FUNC_W-1:0] OP_BLTZ  = 5'd14;
  localparam logic [FUNC_W-1:0] OP_LOAD  = 5'd15;
  localparam logic [FUNC_W-1:0] OP_STORE = 5'd16;

endpackage

// ===== sv/tie_ram.sv =====
// tie_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/toy_instruction_executor.sv =====
// toy_instruction_executor: sequential executor of decoded instructions
// depends on tie_pkg and tie_ram
//
// sequencing: S_RB, S_RD, S_CAP, S_CALC, S_DIV (div with nonzero divisor only;
//   bit-serial divider, one quotient bit per cycle), then S_WB, which waits for
//   the output register; a new instruction is taken only in S_IDLE; register file
//   reads share one ram port, three reads. reset: both memories are swept to zero
//   after rst_ni, with no instruction accepted meanwhile; pc resets to zero
module toy_instruction_executor
  import tie_pkg::*;
#(
  parameter int unsigned NUM_REGS   = 32,
  parameter int unsigned DATA_WORDS = 256,
  parameter int unsigned PC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[4:0], dest_reg[9:5], src_reg_a[14:10], src_reg_b[19:15],
  // immediate[51:20], data_addr[59:52], zero[63:60]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[15:0], branch_taken[16], reg_written[17], written_value[49:18],
  // div_zero[50], zero[55:51]
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned RW    = $clog2(NUM_REGS);
  localparam int unsigned AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned CLR_N = (DATA_WORDS > NUM_REGS) ? DATA_WORDS : NUM_REGS;
  localparam int unsigned CW    = $clog2(CLR_N + 1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;
  localparam logic [2:0] S_CALC = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  // index folding tables: input index taken modulo depth
  function automatic logic [RW-1:0] reg_fold(input logic [RIDX_IN-1:0] idx);
    logic [RW-1:0] r;
    r = '0;
    for (int i = 0; i < 2**RIDX_IN; i++) begin
      if (idx == RIDX_IN'(i)) r = RW'(i % NUM_REGS);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_fold(input logic [ADDR_IN-1:0] idx);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < 2**ADDR_IN; i++) begin
      if (idx == ADDR_IN'(i)) r = AW'(i % DATA_WORDS);
    end
    return r;
  endfunction

  // input unpacking
  logic [FUNC_W-1:0]  in_func;
  logic [RIDX_IN-1:0] in_rd, in_ra, in_rb;
  logic [WORD_W-1:0]  in_imm;
  logic [ADDR_IN-1:0] in_addr;
  assign in_func = s_axis_tdata[4:0];
  assign in_rd   = s_axis_tdata[9:5];
  assign in_ra   = s_axis_tdata[14:10];
  assign in_rb   = s_axis_tdata[19:15];
  assign in_imm  = s_axis_tdata[51:20];
  assign in_addr = s_axis_tdata[59:52];

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     clr_q, clr_d;
  logic [PC_BITS-1:0] pc_q, pc_d;

  // latched instruction
  logic [FUNC_W-1:0] func_q;
  logic [RW-1:0]     rd_q, rb_q;
  logic [WORD_W-1:0] imm_q;
  logic [AW-1:0]     addr_q;
  // operands
  logic [WORD_W-1:0] a_q, b_q, dv_q, dm_q;
  // result
  logic [WORD_W-1:0] val_q, val_d;
  logic              wr_q, wr_d, tk_q, tk_d, dz_q, dz_d, st_q, st_d;
  // divider
  logic [WORD_W-1:0] dq_q, dq_d, dr_q, dr_d, dd_q, dd_d;
  logic              dneg_q, dneg_d;
  logic [5:0]        dcnt_q, dcnt_d;
  // output register
  logic              ov_q, ov_d;
  logic [55:0]       od_q, od_d;

  // ram ports
  logic              rf_we, dm_we;
  logic [RW-1:0]     rf_waddr, rf_raddr;
  logic [AW-1:0]     dm_waddr, dm_raddr;
  logic [WORD_W-1:0] rf_wdata, dm_wdata, rf_rdata, dm_rdata;

  tie_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS), .AW(RW)) u_rf (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  tie_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS), .AW(AW)) u_dm (
    .clk_i(clk_i), .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );

  logic in_xfer, out_xfer;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = ov_q && m_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // divider step and helpers
  logic [WORD_W:0]   dshift, dsub;
  logic [WORD_W-1:0] ua, ub, pc_inc, pc_tgt;
  logic [WORD_W-1:0] pc_next_w;
  logic [PC_BITS-1:0] next_pc;
  assign dshift = {dr_q, dq_q[WORD_W-1]};
  assign dsub   = dshift - {1'b0, dd_q};
  assign ua     = a_q[WORD_W-1] ? (~a_q + 1'b1) : a_q;
  assign ub     = b_q[WORD_W-1] ? (~b_q + 1'b1) : b_q;
  assign next_pc   = tk_q ? PC_BITS'(imm_q - 1'b1) : (pc_q + 1'b1);
  assign pc_next_w = WORD_W'(next_pc);
  assign pc_inc    = '0;
  assign pc_tgt    = pc_inc | pc_next_w;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pc_d     = pc_q;
    val_d    = val_q;
    wr_d     = wr_q;
    tk_d     = tk_q;
    dz_d     = dz_q;
    st_d     = st_q;
    dq_d     = dq_q;
    dr_d     = dr_q;
    dd_d     = dd_q;
    dneg_d   = dneg_q;
    dcnt_d   = dcnt_q;
    ov_d     = ov_q && !m_axis_tready;
    od_d     = od_q;
    rf_we    = 1'b0;
    dm_we    = 1'b0;
    rf_waddr = rd_q;
    dm_waddr = addr_q;
    rf_wdata = val_q;
    dm_wdata = val_q;
    rf_raddr = reg_fold(in_ra);
    dm_raddr = addr_fold(in_addr);
    case (state_q)
      S_CLR: begin
        // sweep both memories to zero after reset
        rf_waddr = clr_q[RW-1:0];
        dm_waddr = clr_q[AW-1:0];
        rf_wdata = '0;
        dm_wdata = '0;
        rf_we    = (clr_q < CW'(NUM_REGS));
        dm_we    = (clr_q < CW'(DATA_WORDS));
        clr_d    = clr_q + 1'b1;
        if (clr_q == CW'(CLR_N - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_d = S_RB;
      end
      S_RB: begin
        rf_raddr = rb_q;
        state_d  = S_RD;
      end
      S_RD: begin
        rf_raddr = rd_q;
        state_d  = S_CAP;
      end
      S_CAP: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        val_d   = '0;
        wr_d    = 1'b0;
        tk_d    = 1'b0;
        dz_d    = 1'b0;
        st_d    = 1'b0;
        state_d = S_WB;
        case (func_q)
          OP_ADD:  begin val_d = a_q + b_q; wr_d = 1'b1; end
          OP_SUB:  begin val_d = a_q - b_q; wr_d = 1'b1; end
          OP_MULT: begin val_d = WORD_W'(a_q * b_q); wr_d = 1'b1; end
          OP_DIV: begin
            if (b_q == '0) begin
              dz_d = 1'b1;
            end else begin
              dq_d    = ua;
              dr_d    = '0;
              dd_d    = ub;
              dneg_d  = a_q[WORD_W-1] ^ b_q[WORD_W-1];
              dcnt_d  = '0;
              wr_d    = 1'b1;
              state_d = S_DIV;
            end
          end
          OP_LI:    begin val_d = imm_q; wr_d = 1'b1; end
          OP_INC:   begin val_d = dv_q + 1'b1; wr_d = 1'b1; end
          OP_DEC:   begin val_d = dv_q - 1'b1; wr_d = 1'b1; end
          OP_JUMP:  tk_d = 1'b1;
          OP_BEQ:   tk_d = (a_q == b_q);
          OP_BNE:   tk_d = (a_q != b_q);
          OP_BGEZ:  tk_d = !a_q[WORD_W-1];
          OP_BGTZ:  tk_d = !a_q[WORD_W-1] && (a_q != '0);
          OP_BLEZ:  tk_d = a_q[WORD_W-1] || (a_q == '0);
          OP_BLTZ:  tk_d = a_q[WORD_W-1];
          OP_LOAD:  begin val_d = dm_q; wr_d = 1'b1; end
          OP_STORE: begin val_d = a_q; st_d = 1'b1; end
          default:  ;
        endcase
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!dsub[WORD_W]) begin
          dr_d = dsub[WORD_W-1:0];
          dq_d = {dq_q[WORD_W-2:0], 1'b1};
        end else begin
          dr_d = dshift[WORD_W-1:0];
          dq_d = {dq_q[WORD_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 6'(WORD_W - 1)) begin
          val_d   = dneg_q ? (~dq_d + 1'b1) : dq_d;
          state_d = S_WB;
        end
      end
      S_WB: begin
        // commit once the output register is free
        if (!ov_q || m_axis_tready) begin
          rf_we   = wr_q;
          dm_we   = st_q;
          pc_d    = next_pc;
          ov_d    = 1'b1;
          od_d    = {5'd0, dz_q, val_q, wr_q, tk_q, pc_tgt[15:0]};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= in_func;
      rd_q   <= reg_fold(in_rd);
      rb_q   <= reg_fold(in_rb);
      imm_q  <= in_imm;
      addr_q <= addr_fold(in_addr);
    end
    if (state_q == S_RB) begin
      a_q  <= rf_rdata;
      dm_q <= dm_rdata;
    end
    if (state_q == S_RD)  b_q  <= rf_rdata;
    if (state_q == S_CAP) dv_q <= rf_rdata;
    val_q  <= val_d;
    wr_q   <= wr_d;
    tk_q   <= tk_d;
    dz_q   <= dz_d;
    st_q   <= st_d;
    dq_q   <= dq_d;
    dr_q   <= dr_d;
    dd_q   <= dd_d;
    dneg_q <= dneg_d;
    dcnt_q <= dcnt_d;
    od_q   <= od_d;
  end

`ifndef SYNTHESIS
  a_clr_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !s_axis_tready)
    else $error("transfer accepted during clearing sweep");
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_RB))
    else $error("sequencer did not start after input transfer");
  a_dz_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[50]) |-> !m_axis_tdata[17])
    else $error("divide by zero reported a register write");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dcnt_q < 6'(WORD_W)))
    else $error("divider overran its step count");
`endif

endmodule
